// File: sv/rgb_to_hsv_pixel_core_macros.svh
// assertion macros shared by the rtl
`ifndef RGB_TO_HSV_PIXEL_CORE_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define R2H_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define R2H_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/r2h_pkg.sv
`default_nettype none
package r2h_pkg;

   // one quotient bit per cell, both dividers yield 8 bits
   localparam int NUM_CELLS = 8;

   // hue offset of each sector in degrees
   localparam logic [8:0] HUE_BASE_RED   = 9'd0;
   localparam logic [8:0] HUE_BASE_GREEN = 9'd120;
   localparam logic [8:0] HUE_BASE_BLUE  = 9'd240;
   localparam logic signed [10:0] HUE_WRAP = 11'sd360;
   localparam logic [8:0] HUE_LIMIT = 9'd360;

   // data handed from cell to cell
   typedef struct packed {
      logic [7:0] delta;   // divisor of the hue lane
      logic [7:0] h_rem;   // hue partial remainder
      logic [7:0] h_qn;    // hue numerator bits out, quotient bits in
      logic [7:0] s_rem;   // saturation partial remainder
      logic [7:0] s_qn;    // saturation numerator bits out, quotient bits in
      logic       neg;     // channel difference was negative
      logic       grey;    // delta is zero
      logic [8:0] base;    // sector offset
      logic [7:0] value;   // also the divisor of the saturation lane
      logic [7:0] alpha;
   } r2h_lane_type;

endpackage
`default_nettype wire

// File: sv/r2h_front.sv
`default_nettype none
module r2h_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           red,
   input  wire logic [7:0]           green,
   input  wire logic [7:0]           blue,
   input  wire logic [7:0]           alpha,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output r2h_pkg::r2h_lane_type     out_lane
);
   import r2h_pkg::*;

   logic               valid_ff, valid_in;
   r2h_lane_type       lane_ff, lane_in;
   logic [7:0]         mx, mn, delta, mag;
   logic               red_max, green_max;
   logic signed [8:0]  diff;
   logic [13:0]        h_num;
   logic [15:0]        h_num16, s_num;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      red_max   = (red == mx);
      green_max = !red_max && (green == mx);
      if (red_max) begin
         diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green_max) begin
         diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         diff = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      mag = diff[8] ? 8'(-diff) : diff[7:0];
      // 60 * mag as 64 * mag - 4 * mag
      h_num   = ({6'b0, mag} << 6) - ({6'b0, mag} << 2);
      h_num16 = {2'b0, h_num};
      // 255 * delta as 256 * delta - delta
      s_num   = {delta, 8'b0} - {8'b0, delta};

      lane_in.delta = delta;
      lane_in.h_rem = h_num16[15:8];
      lane_in.h_qn  = h_num16[7:0];
      lane_in.s_rem = s_num[15:8];
      lane_in.s_qn  = s_num[7:0];
      lane_in.neg   = diff[8];
      lane_in.grey  = (delta == 8'd0);
      lane_in.base  = red_max ? HUE_BASE_RED : (green_max ? HUE_BASE_GREEN : HUE_BASE_BLUE);
      lane_in.value = mx;
      lane_in.alpha = alpha;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule
`default_nettype wire

// File: sv/r2h_cell.sv
`default_nettype none
module r2h_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire r2h_pkg::r2h_lane_type in_lane,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output r2h_pkg::r2h_lane_type     out_lane
);
   import r2h_pkg::*;

   logic          valid_ff, valid_in;
   r2h_lane_type  lane_ff, lane_in;
   logic [8:0]    h_try, s_try, h_sub, s_sub;
   logic          h_take, s_take;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step for each lane, hue over delta, saturation over value
   always_comb begin
      h_try  = {in_lane.h_rem, in_lane.h_qn[7]};
      s_try  = {in_lane.s_rem, in_lane.s_qn[7]};
      h_sub  = h_try - {1'b0, in_lane.delta};
      s_sub  = s_try - {1'b0, in_lane.value};
      h_take = (h_try >= {1'b0, in_lane.delta});
      s_take = (s_try >= {1'b0, in_lane.value});

      lane_in       = in_lane;
      lane_in.h_rem = h_take ? h_sub[7:0] : h_try[7:0];
      lane_in.h_qn  = {in_lane.h_qn[6:0], h_take};
      lane_in.s_rem = s_take ? s_sub[7:0] : s_try[7:0];
      lane_in.s_qn  = {in_lane.s_qn[6:0], s_take};
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule
`default_nettype wire

// File: sv/r2h_back.sv
`default_nettype none
module r2h_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire r2h_pkg::r2h_lane_type in_lane,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [8:0]                hue,
   output logic [7:0]                saturation,
   output logic [7:0]                value,
   output logic [7:0]                alpha
);
   import r2h_pkg::*;

   logic               valid_ff, valid_in;
   logic [8:0]         hue_ff, hue_in;
   logic [7:0]         sat_ff, sat_in, value_ff, alpha_ff;
   logic [8:0]         c_mag;
   logic signed [10:0] h_raw, h_fix;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // ceiling for a positive fraction, plain truncation toward zero otherwise
      c_mag = in_lane.neg ? {1'b0, in_lane.h_qn}
                          : {1'b0, in_lane.h_qn} + {8'b0, |in_lane.h_rem};
      if (in_lane.neg) begin
         h_raw = $signed({2'b0, in_lane.base}) - $signed({2'b0, c_mag});
      end else begin
         h_raw = $signed({2'b0, in_lane.base}) + $signed({2'b0, c_mag});
      end
      h_fix = h_raw[10] ? (h_raw + HUE_WRAP) : h_raw;
      hue_in = in_lane.grey ? 9'd0 : h_fix[8:0];
      sat_in = in_lane.grey ? 8'd0 : in_lane.s_qn;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= in_lane.value;
         alpha_ff <= in_lane.alpha;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign value      = value_ff;
   assign alpha      = alpha_ff;

endmodule
`default_nettype wire

// File: sv/rgb_to_hsv_pixel_core.sv
// rgb to hsv pixel converter
// req_ channel: one rgba pixel per beat (8-bit red, green, blue, alpha_in),
//   taken when req_valid and req_ready are both high
// rsp_ channel: hue in whole degrees 0..359 (ceiling rounded), saturation
//   floor(255*delta/value), value = largest channel, alpha copied through
// pipeline: an accepted req beat passes max/min and numerator set-up, 8 divider
//   cells and hue fix-up, each registered, before it reaches rsp_valid
// throughput: one pixel per clock while rsp_ready stays high; the 8 identical
//   cells each retire one quotient bit of both divisions and pass the pixel on
// every stage has its own valid bit and ready = empty or downstream moving,
//   so bubbles close up and a new pixel enters while a result waits
// when the receiver stalls, the pipe fills and req_ready drops only once
//   all ten stages hold a pixel
// reset (synchronous, active high) empties every stage; nothing else to clear
`default_nettype none
`include "rgb_to_hsv_pixel_core_macros.svh"
module rgb_to_hsv_pixel_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_alpha_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [8:0]      rsp_hue,
   output logic [7:0]      rsp_saturation,
   output logic [7:0]      rsp_value,
   output logic [7:0]      rsp_alpha_out
);
   import r2h_pkg::*;

   // link k feeds cell k; link NUM_CELLS feeds the back end
   r2h_lane_type lane [NUM_CELLS+1];
   logic         vld  [NUM_CELLS+1];
   logic         rdy  [NUM_CELLS+1];

   r2h_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .alpha     (req_alpha_in),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_lane  (lane[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      r2h_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_lane   (lane[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_lane  (lane[k+1])
      );
   end

   r2h_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld[NUM_CELLS]),
      .in_ready   (rdy[NUM_CELLS]),
      .in_lane    (lane[NUM_CELLS]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .value      (rsp_value),
      .alpha      (rsp_alpha_out)
   );

   // hue must always land inside one turn
   `R2H_ASSERT_NOW(a_hue_range, clock, reset, rsp_valid, rsp_hue < HUE_LIMIT, "hue beyond 359")
   // a black pixel has neither hue nor saturation
   `R2H_ASSERT_NOW(a_black_pixel, clock, reset, rsp_valid && (rsp_value == 8'd0),
      (rsp_saturation == 8'd0) && (rsp_hue == 9'd0), "black pixel with colour")
   // an accepted beat must occupy the first stage
   `R2H_ASSERT_NEXT(a_front_fill, clock, reset, req_valid && req_ready, vld[0],
      "accepted beat lost at front")

endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;

   // one converted pixel as it leaves the block
   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] value;
      logic [7:0] alpha;
   } hsv_type;

   // one directed pixel; typed rows carry a hand-worked answer
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      bit         typed;
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] value;
   } pixel_case_type;

   localparam int NUM_DIRECTED  = 22;
   localparam int NUM_RANDOM    = 1250;
   localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES  = 20;    // extra wait after the last answer; the pipe is ten deep
   localparam int HOLD_START    = 300;   // receiver cycle of the long hold-off
   localparam int HOLD_CYCLES   = 60;    // well beyond the ten stages
   localparam int CALM_RX_FIRST = 600;   // receiver window with no idling
   localparam int CALM_RX_LAST  = 1100;
   localparam int CALM_TX_FIRST = 400;   // random items sent with no gaps
   localparam int CALM_TX_LAST  = 700;
   localparam int IDLE_PERCENT  = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic [7:0] req_alpha_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [8:0] rsp_hue;
   logic [7:0] rsp_saturation;
   logic [7:0] rsp_value;
   logic [7:0] rsp_alpha_out;

   hsv_type    pending_hsv = '0;   // answer for the pixel now on the req_ ports
   hsv_type    expected_hsv [$];   // answers of accepted pixels, oldest first
   hsv_type    oldest_hsv;
   int         mismatch_count = 0;
   int         stall_cycles = 0;
   bit         sender_calm = 1'b0;

   // directed pixels: extremes, every sector, ties and the wrap of hue
   pixel_case_type directed_cases [NUM_DIRECTED] = '{
      // black: value 0, so saturation 0 and hue 0
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 9'd0,   8'd0,   8'd0},
      // white: grey at the top
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 9'd0,   8'd0,   8'd255},
      // pure primaries, one per sector
      '{8'd255, 8'd0,   8'd0,   8'h55,  1'b1, 9'd0,   8'd255, 8'd255},
      '{8'd0,   8'd255, 8'd0,   8'haa,  1'b1, 9'd120, 8'd255, 8'd255},
      '{8'd0,   8'd0,   8'd255, 8'h0f,  1'b1, 9'd240, 8'd255, 8'd255},
      // mid and near-black greys
      '{8'd128, 8'd128, 8'd128, 8'hf0,  1'b1, 9'd0,   8'd0,   8'd128},
      '{8'd1,   8'd1,   8'd1,   8'd1,   1'b1, 9'd0,   8'd0,   8'd1},
      // ties for the largest: red beats green, green beats blue
      '{8'd255, 8'd255, 8'd0,   8'd7,   1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd255, 8'd9,   1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255, 8'd3,   1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd90,  8'd90,  8'd90,  8'd2,   1'b0, 9'd0,   8'd0,   8'd0},
      // small negative raw hue rounds up to zero
      '{8'd255, 8'd0,   8'd1,   8'd4,   1'b0, 9'd0,   8'd0,   8'd0},
      // negative raw hue wraps round by a full turn
      '{8'd10,  8'd0,   8'd9,   8'd5,   1'b0, 9'd0,   8'd0,   8'd0},
      // ceiling of a tiny positive hue, then assorted pixels
      '{8'd255, 8'd1,   8'd0,   8'd6,   1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd1,   8'd0,   8'd0,   8'd8,   1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd0,   8'd1,   8'd2,   8'd10,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd200, 8'd100, 8'd50,  8'd11,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd50,  8'd200, 8'd100, 8'd12,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd100, 8'd50,  8'd200, 8'd13,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'h55,  8'haa,  8'h0f,  8'hcc,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'haa,  8'h55,  8'hf0,  8'h33,  1'b0, 9'd0,   8'd0,   8'd0},
      '{8'd255, 8'd254, 8'd253, 8'd128, 1'b0, 9'd0,   8'd0,   8'd0}
   };

   rgb_to_hsv_pixel_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value),
      .rsp_alpha_out  (rsp_alpha_out)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // synchronous reset, asserted from the start, released once and never again
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // exact integer hsv of one pixel: ceiling hue, floor saturation
   function automatic hsv_type convert_rgba(input logic [7:0] red, input logic [7:0] green,
                                            input logic [7:0] blue, input logic [7:0] alpha);
      int      r, g, b;
      int      peak, trough, spread;
      int      sector, diff, numer, degrees;
      hsv_type px;
      r = red;
      g = green;
      b = blue;
      peak = r;
      trough = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      if (g < trough) trough = g;
      if (b < trough) trough = b;
      spread = peak - trough;
      degrees = 0;
      if (spread > 0) begin
         // red is tested before green, green before blue
         if (r == peak) begin
            sector = 0;
            diff = g - b;
         end else if (g == peak) begin
            sector = 2;
            diff = b - r;
         end else begin
            sector = 4;
            diff = r - g;
         end
         numer = 60 * (sector * spread + diff);
         // ceiling for positive numerators, truncation towards zero otherwise
         if (numer >= 0) begin
            degrees = (numer + spread - 1) / spread;
         end else begin
            degrees = -((-numer) / spread);
         end
         if (degrees < 0) degrees += 360;
      end
      px.hue = degrees[8:0];
      px.saturation = (peak > 0) ? 8'((255 * spread) / peak) : 8'd0;
      px.value = peak[7:0];
      px.alpha = alpha;
      return px;
   endfunction

   // one pixel on the req_ channel, with a random gap in front unless calm
   task automatic offer_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha,
                              input hsv_type want);
      while (!sender_calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red      <= red;
      req_green    <= green;
      req_blue     <= blue;
      req_alpha_in <= alpha;
      pending_hsv  <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // sender: directed table, then random pixels, then drain and verdict
   initial begin : drive_pixels
      pixel_case_type row;
      hsv_type        want;
      logic [7:0]     r, g, b, a, top;
      int             kind;
      while (reset) @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_cases[i];
         if (row.typed) begin
            want = '{row.hue, row.saturation, row.value, row.alpha};
         end else begin
            want = convert_rgba(row.red, row.green, row.blue, row.alpha);
         end
         offer_pixel(row.red, row.green, row.blue, row.alpha, want);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         sender_calm = (n >= CALM_TX_FIRST && n < CALM_TX_LAST);
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
         a = 8'($urandom);
         kind = $urandom_range(15);
         // bias a share of pixels towards greys, ties for the largest and negative raw hues
         if (kind == 0) begin
            g = r;
            b = r;
         end else if (kind == 1) begin
            top = 8'($urandom_range(255, 1));
            r = top;
            g = top;
            b = 8'($urandom_range(top));
         end else if (kind == 2) begin
            top = 8'($urandom_range(255, 1));
            g = top;
            b = top;
            r = 8'($urandom_range(top));
         end else if (kind == 3) begin
            top = 8'($urandom_range(255, 1));
            r = top;
            b = top;
            g = 8'($urandom_range(top));
         end else if (kind == 4) begin
            // red largest with blue above green: negative raw hue
            r = 8'($urandom_range(255, 2));
            g = 8'($urandom_range(r - 1));
            b = 8'($urandom_range(r, g + 1));
         end
         offer_pixel(r, g, b, a, convert_rgba(r, g, b, a));
      end
      sender_calm = 1'b0;
      req_valid <= 1'b0;

      // let the monitor log the last beat, then wait for every answer
      @(posedge clock);
      while (expected_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // receiver: random stalls, one calm window and one long hold-off
   initial begin : take_results
      int rx_cycle;
      bit held;
      rx_cycle = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (!held && rx_cycle == HOLD_START) begin
            // keep the output blocked so the pipe fills and req_ready drops
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (rx_cycle >= CALM_RX_FIRST && rx_cycle < CALM_RX_LAST) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // monitor: sample both channels at the edge, check results in order
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hsv.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual hue %0d sat %0d",
                        $time, rsp_hue, rsp_saturation);
               mismatch_count++;
            end else begin
               oldest_hsv = expected_hsv.pop_front();
               compare_field("hue", oldest_hsv.hue, rsp_hue);
               compare_field("saturation", oldest_hsv.saturation, rsp_saturation);
               compare_field("value", oldest_hsv.value, rsp_value);
               compare_field("alpha_out", oldest_hsv.alpha, rsp_alpha_out);
            end
         end
         if (req_valid && req_ready) expected_hsv.push_back(pending_hsv);

         // watchdog on cycles with no beat either way
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire

// File: rgb_to_hsv_pixel_core.f
+incdir+sv
sv/r2h_pkg.sv
sv/r2h_front.sv
sv/r2h_cell.sv
sv/r2h_back.sv
sv/rgb_to_hsv_pixel_core.sv
bench/tb.sv
